/* src/assert_macros.svh */
// assertion macros used by the rtl files (lslp_window)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond in this cycle implies expr in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("%m: next-cycle check failed");

// cond implies expr in the same cycle
`define ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("%m: same-cycle check failed");

`endif

/* src/lslp_pkg.sv */
// constants, types and tap weights of the least-squares linear predictor
package lslp_pkg;

  localparam int WindowLen = 8;
  localparam int HistLen   = WindowLen - 1;
  localparam int SampleW   = 32;
  localparam int WeightW   = 18;
  localparam int FracBits  = 16;
  localparam int ProdW     = SampleW + WeightW;
  localparam int AccW      = ProdW + $clog2(WindowLen) + 1;
  localparam int GroupSize = 8;
  localparam int NumGroups = (WindowLen + GroupSize - 1) / GroupSize;
  localparam int PadLen    = NumGroups * GroupSize;

  localparam longint WeightScale = 64'sd131072;
  localparam longint WeightDen   = longint'(WindowLen) * longint'(WindowLen - 1);
  localparam longint WeightHalf  = WeightDen / 2;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AccW-1:0]    acc_t;

  localparam acc_t RoundBias = acc_t'(longint'(1) << (FracBits - 1));
  localparam acc_t SatMax    = acc_t'((longint'(1) << (SampleW - 1)) - 1);
  localparam acc_t SatMin    = acc_t'(-(longint'(1) << (SampleW - 1)));

  // q.16 weight of tap idx, rounded to nearest with ties away from zero
  function automatic weight_t tap_weight(input int idx);
    longint num;
    longint q;
    num = WeightScale * (3 * longint'(idx) - longint'(WindowLen) + 1);
    if (num >= 0) begin
      q = (num + WeightHalf) / WeightDen;
    end else begin
      q = -((-num + WeightHalf) / WeightDen);
    end
    return weight_t'(q);
  endfunction

endpackage

/* src/lslp_in_if.sv */
// sample channel: valid/ready handshake with one signed sample
interface lslp_in_if;
  logic               valid;
  logic               ready;
  lslp_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* src/lslp_out_if.sv */
// prediction channel: valid/ready handshake with one signed prediction
interface lslp_out_if;
  logic               valid;
  logic               ready;
  lslp_pkg::sample_t  predicted;

  modport source (output valid, output predicted, input ready);
  modport sink   (input valid, input predicted, output ready);
endinterface

/* src/lslp_window.sv */
// sample history and registered window of taps
`include "assert_macros.svh"

module lslp_window (
  input  logic                clk,
  input  logic                rst,
  lslp_in_if.sink             samples,
  output logic                win_valid,
  input  logic                win_ready,
  output lslp_pkg::sample_t   window [lslp_pkg::WindowLen]
);

  lslp_pkg::sample_t history [lslp_pkg::HistLen];
  logic              accept;

  assign samples.ready = !win_valid || win_ready;
  assign accept        = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      for (int k = 0; k < lslp_pkg::HistLen; k++) begin
        history[k] <= '0;
      end
    end else begin
      if (accept) begin
        win_valid <= 1'b1;
      end else if (win_ready) begin
        win_valid <= 1'b0;
      end
      if (accept) begin
        for (int k = 0; k < lslp_pkg::HistLen - 1; k++) begin
          history[k] <= history[k+1];
        end
        history[lslp_pkg::HistLen-1] <= samples.sample;
      end
    end
  end

  // window snapshot: oldest first, new sample last
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < lslp_pkg::HistLen; k++) begin
        window[k] <= history[k];
      end
      window[lslp_pkg::HistLen] <= samples.sample;
    end
  end

  `ASSERT_NEXT(a_win_takes_sample, clk, rst, accept, win_valid && window[lslp_pkg::HistLen] == $past(samples.sample))
  `ASSERT_NEXT(a_hist_newest, clk, rst, accept, history[lslp_pkg::HistLen-1] == window[lslp_pkg::HistLen])
  `ASSERT_NEXT(a_hist_hold, clk, rst, !accept, $stable(history[0]) && $stable(history[lslp_pkg::HistLen-1]))
  `ASSERT_NEXT(a_win_hold, clk, rst, win_valid && !win_ready, win_valid && $stable(window[0]))

endmodule

/* src/lslp_mac.sv */
// constant-weight products and grouped partial sums, two register stages
module lslp_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                win_valid,
  output logic                win_ready,
  input  lslp_pkg::sample_t   window [lslp_pkg::WindowLen],
  output logic                grp_valid,
  input  logic                grp_ready,
  output lslp_pkg::acc_t      group_sum [lslp_pkg::NumGroups]
);

  logic              prod_valid;
  logic              prod_ready;
  logic              grp_take;
  lslp_pkg::prod_t   prod [lslp_pkg::WindowLen];
  lslp_pkg::prod_t   prod_pad [lslp_pkg::PadLen];
  lslp_pkg::acc_t    group_next [lslp_pkg::NumGroups];

  // partial-sum stage loads when empty or when its contents move on
  assign grp_take   = !grp_valid || grp_ready;
  assign prod_ready = !prod_valid || grp_take;
  assign win_ready  = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      grp_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= win_valid;
      end
      if (grp_take) begin
        grp_valid <= prod_valid;
      end
    end
  end

  // one constant multiplier per tap
  for (genvar k = 0; k < lslp_pkg::WindowLen; k++) begin : g_tap
    localparam lslp_pkg::weight_t TapWeight = lslp_pkg::tap_weight(k);
    always_ff @(posedge clk) begin
      if (prod_ready && win_valid) begin
        prod[k] <= window[k] * TapWeight;
      end
    end
  end

  for (genvar i = 0; i < lslp_pkg::PadLen; i++) begin : g_pad
    if (i < lslp_pkg::WindowLen) begin : g_real
      assign prod_pad[i] = prod[i];
    end else begin : g_zero
      assign prod_pad[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < lslp_pkg::NumGroups; g++) begin
      group_next[g] = '0;
      for (int j = 0; j < lslp_pkg::GroupSize; j++) begin
        group_next[g] = group_next[g]
                      + lslp_pkg::acc_t'(prod_pad[g*lslp_pkg::GroupSize + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take && prod_valid) begin
      for (int g = 0; g < lslp_pkg::NumGroups; g++) begin
        group_sum[g] <= group_next[g];
      end
    end
  end

endmodule

/* src/lslp_round.sv */
// final sum, round half-up, saturate and output register
module lslp_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  lslp_pkg::acc_t      group_sum [lslp_pkg::NumGroups],
  lslp_out_if.source          predictions
);

  logic               valid;
  lslp_pkg::sample_t  predicted;
  lslp_pkg::sample_t  predicted_next;
  lslp_pkg::acc_t     total;
  lslp_pkg::acc_t     shifted;

  assign grp_ready             = !valid || predictions.ready;
  assign predictions.valid     = valid;
  assign predictions.predicted = predicted;

  always_comb begin
    total = lslp_pkg::RoundBias;
    for (int g = 0; g < lslp_pkg::NumGroups; g++) begin
      total = total + group_sum[g];
    end
    shifted = total >>> lslp_pkg::FracBits;
    if (shifted > lslp_pkg::SatMax) begin
      predicted_next = lslp_pkg::SatMax[lslp_pkg::SampleW-1:0];
    end else if (shifted < lslp_pkg::SatMin) begin
      predicted_next = lslp_pkg::SatMin[lslp_pkg::SampleW-1:0];
    end else begin
      predicted_next = shifted[lslp_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (grp_ready) begin
      valid <= grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ready && grp_valid) begin
      predicted <= predicted_next;
    end
  end

endmodule

/* src/least_squares_linear_predictor_top.sv */
// top level of the least-squares linear predictor
//
// samples: sink channel, one signed 32-bit position sample per transaction
// predictions: source channel, one signed 32-bit prediction per transaction,
//   the least-squares line through the last eight samples taken one step ahead
// every accepted sample gives exactly one prediction, in order
// pipeline: window register, product register, partial-sum register and
//   output register
// throughput: one sample per cycle while the receiver is ready, set by the
//   four-stage register pipeline (one constant multiplier per tap)
// each stage holds while the stage after it is full and stalled, so bubbles
//   close up and a new sample is taken while a prediction waits
// a stalled receiver fills the pipeline after four transactions, then
//   samples.ready drops until predictions are taken
// reset clears the history to zero (those zeros act as real samples in the
//   first fits) and empties every pipeline stage
module least_squares_linear_predictor_top (
  input  logic        clk,
  input  logic        rst,
  lslp_in_if.sink     samples,
  lslp_out_if.source  predictions
);

  // window stage to multiply stage
  logic               win_valid;
  logic               win_ready;
  lslp_pkg::sample_t  window [lslp_pkg::WindowLen];

  // partial-sum stage to output stage
  logic               grp_valid;
  logic               grp_ready;
  lslp_pkg::acc_t     group_sum [lslp_pkg::NumGroups];

  // history shift and snapshot of the full window per sample
  lslp_window u_window (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .window    (window)
  );

  // constant-weight taps and partial sums of up to eight products
  lslp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .window    (window),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .group_sum (group_sum)
  );

  // q.16 rounding and clamp to the 32-bit range
  lslp_round u_round (
    .clk         (clk),
    .rst         (rst),
    .grp_valid   (grp_valid),
    .grp_ready   (grp_ready),
    .group_sum   (group_sum),
    .predictions (predictions)
  );

endmodule
